// ----- rtl/stereo_correlation_meter_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef STEREO_CORRELATION_METER_MACROS_SVH
`define STEREO_CORRELATION_METER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define SCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/scm_pkg.sv -----
// package: shared constants and types of the stereo correlation meter
package scm_pkg;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ACC_BITS_DEF    = 48;
  localparam int ALPHA_W         = 32;
  localparam int GATE_W          = 47;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 47;
  localparam int CORR_W          = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MONO  = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 32'd447372;
  localparam logic [GATE_W-1:0]  GATE_RST  = 47'd70368744;
  localparam logic [GATE_W-1:0]  FLOOR_RST = 47'd70;

  // control flags of a sample handed from front to back
  typedef struct packed {
    logic last;
    logic clear_hold;
  } scm_ctl_t;
endpackage

// ----- rtl/scm_front.sv -----
// front end: takes samples, applies mono mode, detects transport start
module scm_front #(
  parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mono,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic signed [SAMPLE_BITS-1:0] s_left,
  input  logic signed [SAMPLE_BITS-1:0] s_right,
  input  logic                          s_last,
  input  logic                          s_playing,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [SAMPLE_BITS-1:0] q_left,
  output logic signed [SAMPLE_BITS-1:0] q_right,
  output scm_pkg::scm_ctl_t             q_ctl
);
  import scm_pkg::*;
  localparam int QW = 2 * SAMPLE_BITS + 2;
  localparam int DEPTH = 2;

  logic [QW-1:0] mem_r [DEPTH];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          prev_play_r;
  logic          push, pop;
  logic signed [SAMPLE_BITS-1:0] r_eff;

  assign s_ready = (cnt_r != 2'd2);
  assign push    = s_valid && s_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign r_eff   = mono ? s_left : s_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      prev_play_r <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        prev_play_r <= s_playing;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= {s_left, r_eff, s_last, s_playing & ~prev_play_r};
  end

  assign q_left       = mem_r[rp_r][QW-1 -: SAMPLE_BITS];
  assign q_right      = mem_r[rp_r][SAMPLE_BITS+1 -: SAMPLE_BITS];
  assign q_ctl.last       = mem_r[rp_r][1];
  assign q_ctl.clear_hold = mem_r[rp_r][0];
endmodule

// ----- rtl/scm_back.sv -----
// back end: smoothing, square root, divide and minimum hold
module scm_back #(
  parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = scm_pkg::ACC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scm_pkg::ALPHA_W-1:0]   alpha,
  input  logic [scm_pkg::GATE_W-1:0]    gate,
  input  logic [scm_pkg::GATE_W-1:0]    dfloor,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [SAMPLE_BITS-1:0] q_left,
  input  logic signed [SAMPLE_BITS-1:0] q_right,
  input  scm_pkg::scm_ctl_t             q_ctl,
  output logic                          o_valid,
  input  logic                          o_ready,
  output logic signed [scm_pkg::CORR_W-1:0] o_corr,
  output logic signed [scm_pkg::CORR_W-1:0] o_min,
  output logic                          o_min_valid,
  output logic                          o_sig
);
  import scm_pkg::*;
  localparam int PW  = 2 * SAMPLE_BITS;        // product width
  localparam int DW  = 66;                      // difference width, holds any sum
  localparam int MW  = 65;                      // magnitude width
  localparam int HIW = MW - ALPHA_W;            // upper magnitude slice
  localparam int SW  = ACC_BITS;                // sqrt result width
  localparam int SQB = 7;
  localparam int XW  = 2 * ACC_BITS;            // ll*rr width
  localparam int HW  = (ACC_BITS + 1) / 2;      // half accumulator for the split multiply
  localparam int RW  = SW + 3;                  // root remainder width
  localparam logic signed [DW-1:0] LIM = DW'((66'sd1 <<< (ACC_BITS-1)) - 66'sd1);

  typedef enum logic [2:0] {
    S_IDLE, S_SMLO, S_SMHI, S_PMUL, S_SQRT, S_DIV, S_OUT
  } st_t;

  st_t st_r;
  logic signed [ACC_BITS-1:0] pl_r, pr_r;
  logic signed [ACC_BITS:0]   cp_r;
  logic signed [PW-1:0]       ll_r, rr_r, lr_r;
  logic                       last_r;
  logic [1:0]                 sel_r;
  logic [MW-1:0]              mag_r;
  logic                       neg_r;
  logic [SQB-1:0]             bit_r;
  logic [SW-1:0]              root_r;
  logic [XW-1:0]              prod_r;
  logic [SW:0]                rem_r;
  logic [4:0]                 qn_r;
  logic [15:0]                q_r;
  logic signed [15:0]         corr_r;
  logic signed [15:0]         hmin_r;
  logic                       hval_r;
  logic [SW+1:0]              lo_half;
  logic [ALPHA_W:0]           lo_r;
  logic [HIW-1:0]             mhi_r;
  logic                       dn_r;
  logic [1:0]                 pm_r;
  logic [RW-1:0]              srem_r;

  // smoothing datapath on selected accumulator
  logic signed [DW-1:0] acc_s, x_s, diff_s, res_s, lo_s;
  logic [MW-1:0]  m_s;
  logic [2*ALPHA_W-1:0] lo_mul;
  logic [2*ALPHA_W:0]   lo_sum;
  logic [MW-1:0]  hi_mul;
  logic [MW-1:0]  stp_s;

  always_comb begin
    case (sel_r)
      2'd0: begin acc_s = DW'(pl_r); x_s = DW'(ll_r); lo_s = '0; end
      2'd1: begin acc_s = DW'(pr_r); x_s = DW'(rr_r); lo_s = '0; end
      default: begin acc_s = DW'(cp_r); x_s = DW'(lr_r); lo_s = -LIM; end
    endcase
    diff_s = x_s - acc_s;
    m_s    = diff_s[DW-1] ? MW'(-diff_s) : MW'(diff_s);
  end
  // step = hi * alpha + round(lo * alpha / 2^32), split over S_SMLO and S_SMHI
  assign lo_mul = m_s[ALPHA_W-1:0] * alpha;
  assign lo_sum = {1'b0, lo_mul} + (2*ALPHA_W+1)'(33'h080000000);
  assign hi_mul = mhi_r * alpha;
  assign stp_s  = hi_mul + MW'(lo_r);
  always_comb begin
    res_s = dn_r ? acc_s - DW'(stp_s) : acc_s + DW'(stp_s);
    if (res_s < lo_s) res_s = lo_s;
    if (res_s > LIM)  res_s = LIM;
  end

  // pl*pr from four half-width partial products
  logic [HW-1:0]   opa, opb;
  logic [2*HW-1:0] part;
  logic [XW-1:0]   pp;
  always_comb begin
    opa  = pm_r[1] ? HW'(pl_r[ACC_BITS-1:HW]) : pl_r[HW-1:0];
    opb  = pm_r[0] ? HW'(pr_r[ACC_BITS-1:HW]) : pr_r[HW-1:0];
    part = opa * opb;
    case (pm_r)
      2'd0: pp = XW'(part);
      2'd1, 2'd2: pp = XW'(part) << HW;
      default: pp = XW'(part) << (2*HW);
    endcase
  end

  // digit-by-digit root, two radicand bits per step
  logic [RW-1:0] srem_sh, trial;
  assign srem_sh = {srem_r[RW-3:0], prod_r[XW-1 -: 2]};
  assign trial   = RW'({root_r, 2'b01});

  logic live;
  assign live = ($unsigned(pl_r) > ACC_BITS'(gate)) && ($unsigned(pr_r) > ACC_BITS'(gate));
  assign lo_half = {rem_r, 1'b0};

  assign q_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pl_r <= '0; pr_r <= '0; cp_r <= '0;
      hmin_r <= '0; hval_r <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (q_valid) begin
          ll_r <= q_left * q_left;
          rr_r <= q_right * q_right;
          lr_r <= q_left * q_right;
          last_r <= q_ctl.last;
          if (q_ctl.clear_hold) hval_r <= 1'b0;
          sel_r <= 2'd0;
          st_r <= S_SMLO;
        end
        S_SMLO: begin
          lo_r  <= lo_sum[2*ALPHA_W:ALPHA_W];
          mhi_r <= m_s[MW-1:ALPHA_W];
          dn_r  <= diff_s[DW-1];
          st_r  <= S_SMHI;
        end
        S_SMHI: begin
          case (sel_r)
            2'd0: pl_r <= ACC_BITS'(res_s);
            2'd1: pr_r <= ACC_BITS'(res_s);
            default: cp_r <= (ACC_BITS+1)'(res_s);
          endcase
          sel_r <= sel_r + 2'd1;
          if (sel_r == 2'd2) begin
            prod_r <= '0;
            pm_r   <= 2'd0;
            st_r   <= last_r ? S_PMUL : S_IDLE;
          end else st_r <= S_SMLO;
        end
        S_PMUL: begin
          prod_r <= prod_r + pp;
          pm_r   <= pm_r + 2'd1;
          if (pm_r == 2'd3) begin
            root_r <= '0;
            srem_r <= '0;
            bit_r  <= SQB'(SW-1);
            neg_r  <= cp_r[ACC_BITS];
            mag_r  <= cp_r[ACC_BITS] ? MW'(-cp_r) : MW'(cp_r);
            st_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          prod_r <= prod_r << 2;
          if (srem_sh >= trial) begin
            srem_r <= srem_sh - trial;
            root_r <= {root_r[SW-2:0], 1'b1};
          end else begin
            srem_r <= srem_sh;
            root_r <= {root_r[SW-2:0], 1'b0};
          end
          if (bit_r == '0) begin
            st_r <= S_DIV;
            qn_r <= '0;
            q_r  <= '0;
          end else bit_r <= bit_r - 1'b1;
        end
        S_DIV: begin
          if (qn_r == 5'd0) begin
            rem_r <= (SW+1)'(mag_r);
            if (root_r <= SW'(dfloor)) begin
              corr_r <= '0; st_r <= S_OUT;
            end else if (mag_r >= MW'(root_r)) begin
              corr_r <= neg_r ? $signed(16'h8000) : 16'sd32767; st_r <= S_OUT;
            end else qn_r <= 5'd1;
          end else if (qn_r <= 5'd15) begin
            if ({rem_r, 1'b0} >= (SW+2)'(root_r)) begin
              rem_r <= (SW+1)'({rem_r, 1'b0} - (SW+2)'(root_r));
              q_r <= {q_r[14:0], 1'b1};
            end else begin
              rem_r <= (SW+1)'({rem_r, 1'b0});
              q_r <= {q_r[14:0], 1'b0};
            end
            qn_r <= qn_r + 1'b1;
          end else begin
            // round half away: rem >= denom - rem, +1 saturates to 32767
            if ((SW+2)'(lo_half) >= (SW+2)'(root_r)) begin
              if (neg_r)
                corr_r <= -$signed(q_r + 16'd1);
              else if (q_r == 16'd32767)
                corr_r <= 16'sd32767;
              else
                corr_r <= $signed(q_r + 16'd1);
            end else
              corr_r <= neg_r ? -$signed(q_r) : $signed(q_r);
            st_r <= S_OUT;
          end
        end
        S_OUT: if (!o_valid || o_ready) begin
          o_corr <= corr_r;
          o_sig  <= live;
          if (live && (!hval_r || corr_r < hmin_r)) begin
            hmin_r <= corr_r; hval_r <= 1'b1;
            o_min <= corr_r; o_min_valid <= 1'b1;
          end else begin
            o_min <= hval_r ? hmin_r : 16'sd0; o_min_valid <= hval_r;
          end
          o_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (o_valid && o_ready && !(st_r == S_OUT)) o_valid <= 1'b0;
    end
  end
endmodule

// ----- rtl/stereo_correlation_meter.sv -----
// top level: stereo phase correlation meter
// channel | direction | handshake       | payload
// in_     | input     | tvalid/tready   | tdata: left, right; tlast: block end; tuser: playing
// out_    | output    | tvalid/tready   | tdata: corr, min corr, min valid, signal
// cfg_    | input     | write enable    | index, data
// a plain sample holds the back end for its products, then S_SMLO and S_SMHI per smoothing step
// a block-end sample adds the partial-product sum, 48-step root, 17-step divide and output
// a root at or below the floor, or a full-scale result, ends the divide after its first step
// a two-entry queue lets the front take samples while the back end works
// synchronous active-low reset clears accumulators, hold and queue
// a stalled result holds the back end in its output state
module stereo_correlation_meter #(
  parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = scm_pkg::ACC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata, // left_sample, right_sample
  input  logic                            in_tlast,  // block_last
  input  logic                            in_tuser,  // playing
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata, // correlation, min_correlation, min_valid, has_signal
  input  logic                            cfg_we,
  input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scm_pkg::*;
  logic [ALPHA_W-1:0] alpha_r;
  logic [GATE_W-1:0]  gate_r, floor_r;
  logic               mono_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST; gate_r <= GATE_RST; floor_r <= FLOOR_RST; mono_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
        REG_GATE:  gate_r  <= cfg_data[GATE_W-1:0];
        REG_FLOOR: floor_r <= cfg_data[GATE_W-1:0];
        REG_MONO:  mono_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_ready;
  logic signed [SAMPLE_BITS-1:0] q_left, q_right;
  scm_ctl_t q_ctl;
  logic signed [CORR_W-1:0] corr, cmin;
  logic mv, sig;

  scm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .mono(mono_r),
    .s_valid(in_tvalid), .s_ready(in_tready),
    .s_left($signed(in_tdata[SAMPLE_BITS-1:0])),
    .s_right($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .s_last(in_tlast), .s_playing(in_tuser),
    .q_valid, .q_ready, .q_left, .q_right, .q_ctl
  );

  scm_back #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS)) u_back (
    .clk, .rst_n, .alpha(alpha_r), .gate(gate_r), .dfloor(floor_r),
    .q_valid, .q_ready, .q_left, .q_right, .q_ctl,
    .o_valid(out_tvalid), .o_ready(out_tready),
    .o_corr(corr), .o_min(cmin), .o_min_valid(mv), .o_sig(sig)
  );

  assign out_tdata = {6'd0, sig, mv, cmin, corr};
endmodule

// ----- rtl/scm_checker.sv -----
// port-level checker for the correlation meter
`include "stereo_correlation_meter_macros.svh"
module scm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `SCM_ASSERT_NXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SCM_ASSERT_NXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `SCM_ASSERT_IMP(a_min_zero, clk, rst_n, out_tvalid && !out_tdata[32], out_tdata[31:16] == 16'd0)
  `SCM_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0)
endmodule

bind stereo_correlation_meter scm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- sim/stereo_correlation_meter_test.sv -----
// testbench of the stereo correlation meter: directed and random sample streams checked against a predictor
module stereo_correlation_meter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 250;

  // correlation predictor with its own copy of registers and accumulators
  class corr_scoreboard;
    longint unsigned alpha, gate, floor_lvl;
    bit mono;
    longint pow_l, pow_r, xpow;
    logic signed [15:0] held_min;
    bit held_valid, prev_play;
    logic [39:0] expected_q[$];
    int errors, results, live_results, samples;

    function new();
      alpha = ALPHA_RST;
      gate = GATE_RST;
      floor_lvl = FLOOR_RST;
      mono = 0;
      pow_l = 0;
      pow_r = 0;
      xpow = 0;
      held_min = 0;
      held_valid = 0;
      prev_play = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ALPHA: alpha = v[ALPHA_W-1:0];
        REG_GATE:  gate = v;
        REG_FLOOR: floor_lvl = v;
        REG_MONO:  mono = v[0];
        default: ;
      endcase
    endfunction

    function longint smooth(longint acc, longint x, longint lo, longint hi);
      longint unsigned m, stp, r;
      bit neg;
      longint v;
      neg = x < acc;
      m = neg ? acc - x : x - acc;
      stp = (m >> 32) * alpha + (((m & 64'hFFFF_FFFF) * alpha + 64'h8000_0000) >> 32);
      r = neg ? acc - stp : acc + stp;
      v = signed'(r);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function logic signed [15:0] correlate();
      logic [127:0] prod, sq;
      longint unsigned root, cand, mag, rem;
      int q;
      bit neg;
      prod = {64'd0, pow_l} * {64'd0, pow_r};
      root = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        sq = {64'd0, cand} * {64'd0, cand};
        if (sq <= prod) root = cand;
      end
      if (root <= floor_lvl) return 0;
      neg = xpow < 0;
      mag = neg ? -xpow : xpow;
      q = 0;
      if (mag >= root) begin
        q = 32768;
      end else begin
        rem = mag;
        for (int i = 0; i < 15; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= root) begin
            rem = rem - root;
            q = q | 1;
          end
        end
        // round half away from zero
        if (rem >= root - rem) q++;
      end
      if (neg) return -q;
      return (q > 32767) ? 32767 : q;
    endfunction

    function void note_sample(logic signed [23:0] l_in, logic signed [23:0] r_in,
                              bit last, bit play);
      longint l, r, lim;
      logic signed [15:0] c;
      bit live;
      lim = (64'sd1 <<< 47) - 1;
      l = l_in;
      r = mono ? l : longint'(r_in);
      samples++;
      if (play && !prev_play) held_valid = 0;
      prev_play = play;
      pow_l = smooth(pow_l, l * l, 0, lim);
      pow_r = smooth(pow_r, r * r, 0, lim);
      xpow = smooth(xpow, l * r, -lim, lim);
      if (!last) return;
      c = correlate();
      live = (pow_l > gate) && (pow_r > gate);
      if (live && (!held_valid || c < held_min)) begin
        held_min = c;
        held_valid = 1;
      end
      expected_q.push_back({6'd0, live, held_valid, (held_valid ? held_min : 16'sd0), c});
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch in %s: got %0d expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(logic [39:0] d);
      logic [39:0] e;
      if (expected_q.size() == 0) begin
        report("unexpected result", d, 0);
        return;
      end
      e = expected_q.pop_front();
      results++;
      if (e[33]) live_results++;
      if (d[15:0] !== e[15:0]) report("correlation", $signed(d[15:0]), $signed(e[15:0]));
      if (d[31:16] !== e[31:16])
        report("min_correlation", $signed(d[31:16]), $signed(e[31:16]));
      if (d[32] !== e[32]) report("min_valid", d[32], e[32]);
      if (d[33] !== e[33]) report("has_signal", d[33], e[33]);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tlast = 0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  corr_scoreboard sb = new();
  bit steady = 0;
  bit hold_start = 0;
  int hold_cnt = 0;
  int cycles = 0;
  bit playing = 0;

  always #5 clk = ~clk;

  stereo_correlation_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_start) begin
      hold_start = 0;
      hold_cnt = 800;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
    out_tready <= (hold_cnt == 0) && (steady || $urandom_range(99) >= 14);
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic apply_setting(logic [31:0] a, logic [46:0] g, logic [46:0] f, bit m);
    cfg_write(REG_ALPHA, {15'd0, a});
    cfg_write(REG_GATE, g);
    cfg_write(REG_FLOOR, f);
    cfg_write(REG_MONO, {46'd0, m});
  endtask

  task automatic send_request(logic [23:0] l, logic [23:0] r, bit last, bit play);
    in_tdata <= {r, l};
    in_tlast <= last;
    in_tuser <= play;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(l, r, last, play);
    if (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // samples without a result may still be in the back end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_pair(output logic [23:0] l, output logic [23:0] r);
    int sh;
    l = 24'($urandom);
    r = 24'($urandom);
    sh = $urandom_range(1, 12);
    case ($urandom_range(5))
      0: ;
      1: r = l;
      2: r = -l;
      3: r = $signed(l) >>> sh;
      4: begin
        l = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
        r = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      end
      default: begin
        l = $signed(l) >>> 14;
        r = $signed(r) >>> 14;
      end
    endcase
  endtask

  task automatic random_blocks(int n_items, bit with_hold);
    logic [23:0] l, r;
    int len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 3) playing = ~playing;
        random_pair(l, r);
        send_request(l, r, i == len - 1, playing);
        sent++;
        if (with_hold && sent == n_items / 2) hold_start = 1;
      end
    end
  endtask

  initial begin
    logic [23:0] dl[10] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF, 24'h800000,
                            24'h000001, 24'hFFFFFF, 24'h400000, 24'h7FFFFF, 24'h123456};
    logic [23:0] dr[10] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000, 24'h7FFFFF,
                            24'hFFFFFF, 24'h000001, 24'hC00000, 24'h000000, 24'h123456};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: full-scale pairs, opposite and equal channels, playing edges
    steady = 1;
    apply_setting(32'hFFFF_FFFF, 47'd0, 47'd0, 0);
    for (int i = 0; i < 10; i++) send_request(dl[i], dr[i], 1, i >= 2);
    send_request(24'h7FFFFF, 24'h000000, 0, 0);
    send_request(24'h000000, 24'h7FFFFF, 1, 1);
    send_request(24'h000000, 24'h000000, 1, 1);
    drain();
    apply_setting(ALPHA_RST, GATE_RST, FLOOR_RST, 1);
    send_request(24'h7FFFFF, 24'h800000, 1, 1);
    send_request(24'h800000, 24'h7FFFFF, 1, 0);
    send_request(24'h000000, 24'h000000, 1, 1);
    drain();

    steady = 0;
    apply_setting(32'h4000_0000, GATE_RST, FLOOR_RST, 0);
    random_blocks(320, 1);
    drain();
    apply_setting(32'hFFFF_FFFF, 47'd0, 47'd0, 1);
    random_blocks(250, 0);
    drain();
    steady = 1;
    apply_setting($urandom_range(32'h7FFF_FFFF, 32'h0100_0000),
                  47'({$urandom_range(3), $urandom}), 47'($urandom_range(5000)), 0);
    random_blocks(300, 0);
    drain();
    steady = 0;
    apply_setting(32'd0, 47'h4000_0000_0000, 47'h4000_0000_0000, 0);
    random_blocks(120, 0);
    drain();
    apply_setting(32'h1000_0000, 47'h0000_0100_0000, 47'd1000, 0);
    random_blocks(320, 0);
    drain();
    apply_setting(ALPHA_RST, GATE_RST, FLOOR_RST, 0);
    random_blocks(250, 0);
    drain();
    apply_setting(32'h8000_0000, 47'd1, 47'd1, 1);
    random_blocks(270, 0);
    drain();

    $display("covered %0d samples and %0d block results, %0d of them above the energy gate",
             sb.samples, sb.results, sb.live_results);
    $display("register settings spanned zero and full-scale smoothing, gates and floors, mono");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/scm_pkg.sv
rtl/scm_front.sv
rtl/scm_back.sv
rtl/stereo_correlation_meter.sv
rtl/scm_checker.sv
sim/stereo_correlation_meter_test.sv
